// ----- src/led_priority_blink_controller_defines.svh -----
// assertion macros shared by the checker of the light controller
// expects clk and rst to be visible where a macro is used
`ifndef LED_PRIORITY_BLINK_CONTROLLER_DEFINES_SVH
`define LED_PRIORITY_BLINK_CONTROLLER_DEFINES_SVH

// same-cycle implication, off while in reset
`define LPBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define LPBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lpbc_pkg.sv -----
// shared types, widths and constants of the light controller
// no dependencies
`timescale 1ns / 1ps

package lpbc_pkg;

  // field widths
  localparam int LIGHT_ID_W = 3;
  localparam int COLOR_W    = 24;
  localparam int MS_W       = 16;
  localparam int LUMA_W     = 8;
  localparam int BACKLIGHT_W = 16;
  localparam int LEVEL_W    = 8;
  localparam int BLINK_W    = 26;
  localparam int PANEL_W    = 16;

  // divider widths: dividend covers on*255, divisor covers on+off
  localparam int DIV_DVD_W = 24;
  localparam int DIV_DSR_W = 17;

  // backlight scaling: x = luma*panel_max, x/255 = (x*RECIP_255) >> 32, exact below 2^24
  localparam int SCALED_W     = 24;
  localparam int RECIP_W      = 25;
  localparam int RECIP_SHIFT  = 32;
  localparam int SCALE_PROD_W = SCALED_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;

  // light ids
  localparam logic [LIGHT_ID_W-1:0] LIGHT_BACKLIGHT = 3'd0;
  localparam logic [LIGHT_ID_W-1:0] LIGHT_BATTERY   = 3'd3;
  localparam logic [LIGHT_ID_W-1:0] LIGHT_NOTIF     = 3'd4;
  localparam logic [LIGHT_ID_W-1:0] LIGHT_ATTN      = 3'd5;

  // stored request slots, in priority order
  localparam int SLOT_NOTIF = 0;
  localparam int SLOT_ATTN  = 1;
  localparam int SLOT_BATT  = 2;
  localparam int SLOT_N     = 3;

  // register word index
  localparam logic REG_PANEL_MAX = 1'b0;

  // constants
  localparam logic [PANEL_W-1:0]   PANEL_UNSCALED = 16'd255;
  localparam logic [PANEL_W-1:0]   PANEL_RESET    = 16'd255;
  localparam logic [BLINK_W-1:0]   BLINK_STEADY   = 26'd100;
  localparam logic [BLINK_W-1:0]   PERIOD_SCALE   = 26'd1000;
  localparam logic [LEVEL_W-1:0]   DUTY_MIN       = 8'd16;

  // result codes
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_UNSUPPORTED = 1'b1;

  // one stored light request
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               timed;
    logic [MS_W-1:0]    on_ms;
    logic [MS_W-1:0]    off_ms;
  } light_req_t;

  // divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
  } div_rsp_t;

  // (77r + 150g + 29b) >> 8
  function automatic logic [LUMA_W-1:0] luma_of(input logic [COLOR_W-1:0] c);
    logic [15:0] s;
    s = 16'(c[23:16]) * 16'd77 + 16'(c[15:8]) * 16'd150 + 16'(c[7:0]) * 16'd29;
    return s[15:8];
  endfunction

endpackage

// ----- src/lpbc_if.sv -----
// request and result channel interfaces of the light controller
// depends on lpbc_pkg
`timescale 1ns / 1ps

interface lpbc_req_if import lpbc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LIGHT_ID_W-1:0] light_id;
  logic [COLOR_W-1:0]    color;
  logic                  flash_timed;
  logic [MS_W-1:0]       on_ms;
  logic [MS_W-1:0]       off_ms;

  modport source (output valid, light_id, color, flash_timed, on_ms, off_ms, input ready);
  modport sink   (input valid, light_id, color, flash_timed, on_ms, off_ms, output ready);
endinterface

interface lpbc_rsp_if import lpbc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   status;
  logic [BACKLIGHT_W-1:0] backlight_level;
  logic [LEVEL_W-1:0]     red_level;
  logic [LEVEL_W-1:0]     green_level;
  logic [BLINK_W-1:0]     red_flash;
  logic [BLINK_W-1:0]     green_flash;

  modport source (output valid, status, backlight_level, red_level, green_level,
                  red_flash, green_flash, input ready);
  modport sink   (input valid, status, backlight_level, red_level, green_level,
                  red_flash, green_flash, output ready);
endinterface

// ----- src/lpbc_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// depends on lpbc_pkg
`timescale 1ns / 1ps

module lpbc_div import lpbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_DVD_W);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DVD_W-1:0] dvd;
  logic [DIV_DSR_W-1:0] rem;
  logic [DIV_DSR_W-1:0] dsr;
  logic [DIV_DSR_W:0]   rem_sh;
  logic [DIV_DSR_W:0]   diff;
  logic                 ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, dvd[DIV_DVD_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = (rem_sh >= {1'b0, dsr});
  end

  // iteration: dividend bits shift out on top, quotient bits shift in below
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? diff[DIV_DSR_W-1:0] : rem_sh[DIV_DSR_W-1:0];
        dvd <= {dvd[DIV_DVD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

// ----- src/led_priority_blink_controller.sv -----
// Light controller: one request in, one result out, one request in flight at a time.
// The result is loaded into the output register from ST_DONE: an unsupported id goes
// there directly, a steady or unlit indicator update through ST_SELECT, an unscaled
// backlight through ST_LUMA, a scaled backlight through ST_LUMA, ST_SCALE and ST_RECIP
// (luma times panel_max, then a reciprocal multiply for the divide by 255) and a timed
// blink through ST_SELECT and ST_DIVIDE, which waits on the shared divider (one quotient
// bit per cycle) that forms on*255/(on+off). The request side is ready again from the
// edge that loads the result; a result left waiting holds the next one in its final
// state. The panel_max_brightness register sits at byte address 0.
// depends on lpbc_pkg, lpbc_if, lpbc_div
`timescale 1ns / 1ps

module led_priority_blink_controller import lpbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lpbc_req_if.sink    req,
  lpbc_rsp_if.source  rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUMA,
    ST_SCALE,
    ST_RECIP,
    ST_SELECT,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  state_t state;

  logic [PANEL_W-1:0]      panel_max;
  light_req_t              slots [SLOT_N];
  logic [COLOR_W-1:0]      cur_color;
  logic [LUMA_W-1:0]       luma;
  logic [SCALED_W-1:0]     scaled;
  logic [SCALE_PROD_W-1:0] scale_prod;
  logic                    red_on;
  logic                    green_on;
  logic [BLINK_W-1:0]      period;
  logic                    status;
  logic [BACKLIGHT_W-1:0]  backlight;
  logic [LEVEL_W-1:0]      red_lvl;
  logic [LEVEL_W-1:0]      green_lvl;
  logic [BLINK_W-1:0]      red_flash;
  logic [BLINK_W-1:0]      green_flash;
  logic                    rsp_valid;
  logic                    rsp_load;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  light_req_t              win;
  logic                    win_lit;
  logic                    win_blink;
  logic [LEVEL_W-1:0]      duty;
  logic [LEVEL_W-1:0]      duty_raw;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PANEL_MAX) ? {16'b0, panel_max} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_max <= PANEL_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_PANEL_MAX) begin
      panel_max <= pwdata[PANEL_W-1:0];
    end
  end

  // shared divider
  lpbc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // first lit slot in priority order
  always_comb begin
    win     = '0;
    win_lit = 1'b0;
    if (slots[SLOT_NOTIF].color != '0) begin
      win     = slots[SLOT_NOTIF];
      win_lit = 1'b1;
    end else if (slots[SLOT_ATTN].color != '0) begin
      win     = slots[SLOT_ATTN];
      win_lit = 1'b1;
    end else if (slots[SLOT_BATT].color != '0) begin
      win     = slots[SLOT_BATT];
      win_lit = 1'b1;
    end
    win_blink = win.timed && win.on_ms != '0 && win.off_ms != '0;
  end

  // duty with the low clamp
  always_comb begin
    duty_raw = div_rsp.quotient[LEVEL_W-1:0];
    duty     = (duty_raw != '0 && duty_raw < DUTY_MIN) ? DUTY_MIN : duty_raw;
  end

  // divide by 255 as a reciprocal multiply
  always_comb begin
    scale_prod = SCALE_PROD_W'(scaled) * SCALE_PROD_W'(RECIP_255);
  end

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp_load        = (state == ST_DONE) && (!rsp_valid || rsp.ready);

  // sequencer, light state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rsp_valid     <= 1'b0;
      div_req.start <= 1'b0;
      for (int i = 0; i < SLOT_N; i++) slots[i] <= '0;
      backlight     <= '0;
      red_lvl       <= '0;
      green_lvl     <= '0;
      red_flash     <= '0;
      green_flash   <= '0;
      status        <= STATUS_OK;
    end else begin
      div_req.start <= (state == ST_SELECT) && win_lit && win_blink;
      rsp_valid     <= rsp_load || (rsp_valid && !rsp.ready);
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cur_color <= req.color;
            unique case (req.light_id)
              LIGHT_BACKLIGHT: begin
                status <= STATUS_OK;
                state  <= ST_LUMA;
              end
              LIGHT_BATTERY: begin
                slots[SLOT_BATT] <= {req.color, req.flash_timed, req.on_ms, req.off_ms};
                status           <= STATUS_OK;
                state            <= ST_SELECT;
              end
              LIGHT_NOTIF: begin
                slots[SLOT_NOTIF] <= {req.color, req.flash_timed, req.on_ms, req.off_ms};
                status            <= STATUS_OK;
                state             <= ST_SELECT;
              end
              LIGHT_ATTN: begin
                slots[SLOT_ATTN] <= {req.color, req.flash_timed, req.on_ms, req.off_ms};
                status           <= STATUS_OK;
                state            <= ST_SELECT;
              end
              default: begin
                status <= STATUS_UNSUPPORTED;
                state  <= ST_DONE;
              end
            endcase
          end
        end
        // backlight luma, straight out when unscaled
        ST_LUMA: begin
          if (panel_max == PANEL_UNSCALED) begin
            backlight <= BACKLIGHT_W'(luma_of(cur_color));
            state     <= ST_DONE;
          end else begin
            luma  <= luma_of(cur_color);
            state <= ST_SCALE;
          end
        end
        // luma * panel_max
        ST_SCALE: begin
          scaled <= SCALED_W'(luma) * SCALED_W'(panel_max);
          state  <= ST_RECIP;
        end
        // product / 255
        ST_RECIP: begin
          backlight <= scale_prod[RECIP_SHIFT +: BACKLIGHT_W];
          state     <= ST_DONE;
        end
        // indicator update from the winning slot
        ST_SELECT: begin
          if (!win_lit) begin
            red_lvl     <= '0;
            green_lvl   <= '0;
            red_flash   <= '0;
            green_flash <= '0;
            state       <= ST_DONE;
          end else if (win_blink) begin
            red_flash        <= '0;
            green_flash      <= '0;
            period           <= BLINK_W'(win.off_ms) * PERIOD_SCALE;
            red_on           <= (win.color[23:16] != '0);
            green_on         <= (win.color[15:8] != '0);
            div_req.dividend <= {win.on_ms, 8'b0} - DIV_DVD_W'(win.on_ms);
            div_req.divisor  <= DIV_DSR_W'(win.on_ms) + DIV_DSR_W'(win.off_ms);
            state            <= ST_DIVIDE;
          end else begin
            red_flash   <= BLINK_STEADY;
            green_flash <= BLINK_STEADY;
            red_lvl     <= win.color[23:16];
            green_lvl   <= win.color[15:8];
            state       <= ST_DONE;
          end
        end
        ST_DIVIDE: begin
          if (div_rsp.done) begin
            if (red_on) begin
              red_lvl   <= duty;
              red_flash <= period;
            end else if (green_on) begin
              green_lvl   <= duty;
              green_flash <= period;
            end
            state <= ST_DONE;
          end
        end
        // load the output register once it is free
        ST_DONE: begin
          if (rsp_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      // result payload
      if (rsp_load) begin
        rsp.status          <= status;
        rsp.backlight_level <= backlight;
        rsp.red_level       <= red_lvl;
        rsp.green_level     <= green_lvl;
        rsp.red_flash       <= red_flash;
        rsp.green_flash     <= green_flash;
      end
    end
  end

endmodule

// ----- src/lpbc_checker.sv -----
// port-level checks of the light controller, bound to the top level
// depends on lpbc_pkg, lpbc_if and the assertion macro header
`timescale 1ns / 1ps
`include "led_priority_blink_controller_defines.svh"

module lpbc_checker import lpbc_pkg::*; (
  input logic        clk,
  input logic        rst,
  lpbc_req_if.sink   req,
  lpbc_rsp_if.source rsp
);

  logic [BACKLIGHT_W+2*LEVEL_W+2*BLINK_W:0] rsp_payload;
  logic                                     flash_differ;
  logic                                     one_flash_dark;
  logic                                     steady_any;
  logic                                     flash_equal;

  // result fields seen as one word, and flash mode relations
  assign rsp_payload    = {rsp.status, rsp.backlight_level, rsp.red_level, rsp.green_level,
                           rsp.red_flash, rsp.green_flash};
  assign flash_differ   = (rsp.red_flash != rsp.green_flash);
  assign one_flash_dark = (rsp.red_flash == '0) || (rsp.green_flash == '0);
  assign steady_any     = (rsp.red_flash == BLINK_STEADY) || (rsp.green_flash == BLINK_STEADY);
  assign flash_equal    = (rsp.red_flash == rsp.green_flash);

  // one request at a time: busy right after accepting
  `LPBC_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready, "ready after accept")

  // a stalled result keeps its payload
  `LPBC_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp_payload), "stalled result changed")

  // only one led blinks at a time: when the flash values differ, one of them is dark
  `LPBC_ASSERT_NOW(a_one_blink, rsp.valid && flash_differ, one_flash_dark, "both leds blinking")

  // steady mode is set on both leds together
  `LPBC_ASSERT_NOW(a_steady_pair, rsp.valid && steady_any, flash_equal, "steady on one led only")

endmodule

bind led_priority_blink_controller lpbc_checker u_lpbc_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

// ----- sim/tb.sv -----
// testbench of the light controller: directed table and random requests, checked by a
// predictor of the backlight and indicator registers, with panel_max_brightness changes
// depends on lpbc_pkg, lpbc_if and led_priority_blink_controller
`timescale 1ns / 1ps

module tb;
  import lpbc_pkg::*;

  // ids that the block does not support
  localparam logic [LIGHT_ID_W-1:0] LIGHT_SPARE_1 = 3'd1;
  localparam logic [LIGHT_ID_W-1:0] LIGHT_SPARE_2 = 3'd2;
  localparam logic [LIGHT_ID_W-1:0] LIGHT_SPARE_6 = 3'd6;
  localparam logic [LIGHT_ID_W-1:0] LIGHT_SPARE_7 = 3'd7;

  localparam logic [2:0] PANEL_MAX_ADDR = 3'(REG_PANEL_MAX) << 2;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int CALM_PHASE = 3;
  localparam int DRAIN_CYCLES = 40;
  localparam int REQ_BITS = LIGHT_ID_W + COLOR_W + 1 + 2 * MS_W;

  typedef struct packed {
    logic [LIGHT_ID_W-1:0] light_id;
    logic [COLOR_W-1:0]    color;
    logic                  timed;
    logic [MS_W-1:0]       on_ms;
    logic [MS_W-1:0]       off_ms;
  } light_request_t;

  typedef struct packed {
    logic                   status;
    logic [BACKLIGHT_W-1:0] backlight;
    logic [LEVEL_W-1:0]     red;
    logic [LEVEL_W-1:0]     green;
    logic [BLINK_W-1:0]     red_flash;
    logic [BLINK_W-1:0]     green_flash;
  } light_outputs_t;

  typedef struct packed {
    light_request_t item;
    logic           typed_in;
    light_outputs_t want;
  } stim_row_t;

  localparam light_outputs_t NO_CHECK = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lpbc_req_if req_ch ();
  lpbc_rsp_if rsp_ch ();

  led_priority_blink_controller u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor state, as after reset
  light_req_t slots [SLOT_N] = '{default: '0};
  logic [BACKLIGHT_W-1:0] backlight_q = '0;
  logic [LEVEL_W-1:0] red_q = '0;
  logic [LEVEL_W-1:0] green_q = '0;
  logic [BLINK_W-1:0] red_flash_q = '0;
  logic [BLINK_W-1:0] green_flash_q = '0;
  logic [PANEL_W-1:0] panel_max_q = PANEL_RESET;

  light_outputs_t pending_outputs [$];
  int mismatch_count = 0;
  bit calm = 1'b0;

  // directed requests: extremes, priorities, duty corner cases, unsupported ids
  stim_row_t directed_rows [23] = '{
    '{'{LIGHT_SPARE_1, 24'hffffff, 1'b1, 16'hffff, 16'hffff}, 1'b1,
      '{STATUS_UNSUPPORTED, 16'd0, 8'd0, 8'd0, 26'd0, 26'd0}},
    '{'{LIGHT_BACKLIGHT, 24'hffffff, 1'b0, 16'd0, 16'd0}, 1'b1,
      '{STATUS_OK, 16'd255, 8'd0, 8'd0, 26'd0, 26'd0}},
    '{'{LIGHT_BATTERY, 24'hff0000, 1'b0, 16'd1000, 16'd1000}, 1'b1,
      '{STATUS_OK, 16'd255, 8'hff, 8'd0, BLINK_STEADY, BLINK_STEADY}},
    '{'{LIGHT_BACKLIGHT, 24'h000000, 1'b0, 16'd0, 16'd0}, 1'b1,
      '{STATUS_OK, 16'd0, 8'hff, 8'd0, BLINK_STEADY, BLINK_STEADY}},
    '{'{LIGHT_BACKLIGHT, 24'h123456, 1'b1, 16'd7, 16'd9}, 1'b0, NO_CHECK},
    '{'{LIGHT_NOTIF, 24'h00ff00, 1'b1, 16'd100, 16'd1000}, 1'b0, NO_CHECK},
    '{'{LIGHT_NOTIF, 24'hff0000, 1'b1, 16'd1, 16'hffff}, 1'b0, NO_CHECK},
    '{'{LIGHT_NOTIF, 24'hff8000, 1'b1, 16'd1, 16'd20}, 1'b0, NO_CHECK},
    '{'{LIGHT_NOTIF, 24'hffffff, 1'b1, 16'hffff, 16'hffff}, 1'b0, NO_CHECK},
    '{'{LIGHT_NOTIF, 24'h0000ff, 1'b1, 16'd10, 16'd10}, 1'b0, NO_CHECK},
    '{'{LIGHT_NOTIF, 24'h00ff00, 1'b1, 16'd500, 16'd0}, 1'b0, NO_CHECK},
    '{'{LIGHT_NOTIF, 24'hff00ff, 1'b1, 16'd0, 16'd500}, 1'b0, NO_CHECK},
    '{'{LIGHT_ATTN, 24'hffffff, 1'b0, 16'hffff, 16'hffff}, 1'b0, NO_CHECK},
    '{'{LIGHT_NOTIF, 24'h000000, 1'b1, 16'd300, 16'd300}, 1'b0, NO_CHECK},
    '{'{LIGHT_ATTN, 24'h0000ff, 1'b1, 16'hffff, 16'd1}, 1'b0, NO_CHECK},
    '{'{LIGHT_ATTN, 24'h000000, 1'b0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{LIGHT_BATTERY, 24'h000000, 1'b1, 16'd50, 16'd50}, 1'b0, NO_CHECK},
    '{'{LIGHT_SPARE_2, 24'haaaaaa, 1'b1, 16'haaaa, 16'h5555}, 1'b0, NO_CHECK},
    '{'{LIGHT_SPARE_6, 24'h555555, 1'b0, 16'h5555, 16'haaaa}, 1'b0, NO_CHECK},
    '{'{LIGHT_SPARE_7, 24'h000000, 1'b0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{LIGHT_BACKLIGHT, 24'h010101, 1'b0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{LIGHT_BATTERY, 24'h00ff00, 1'b1, 16'd1, 16'd1}, 1'b0, NO_CHECK},
    '{'{LIGHT_BACKLIGHT, 24'hff00ff, 1'b1, 16'hffff, 16'hffff}, 1'b0, NO_CHECK}
  };

  // random idle cycle on either side, none in the calm phase
  function automatic bit take_a_gap();
    return !calm && ($urandom_range(99) < 17);
  endfunction

  // one stored request drives the indicators
  function automatic void drive_leds(input light_req_t r);
    int unsigned red, green, on_t, off_t, duty, period;
    red = 32'(r.color[23:16]);
    green = 32'(r.color[15:8]);
    on_t = r.timed ? 32'(r.on_ms) : 0;
    off_t = r.timed ? 32'(r.off_ms) : 0;
    if (on_t != 0 && off_t != 0) begin
      duty = (on_t * 255) / (on_t + off_t);
      period = off_t * 32'(PERIOD_SCALE);
      if (duty > 0 && duty < 32'(DUTY_MIN)) duty = 32'(DUTY_MIN);
      red_flash_q = '0;
      green_flash_q = '0;
      if (red != 0) begin
        red_q = duty[7:0];
        red_flash_q = period[BLINK_W-1:0];
      end else if (green != 0) begin
        green_q = duty[7:0];
        green_flash_q = period[BLINK_W-1:0];
      end
    end else begin
      red_flash_q = BLINK_STEADY;
      green_flash_q = BLINK_STEADY;
      red_q = red[7:0];
      green_q = green[7:0];
    end
  endfunction

  // highest-priority lit request wins, else everything dark
  function automatic void refresh_indicators();
    if (slots[SLOT_NOTIF].color != 0) drive_leds(slots[SLOT_NOTIF]);
    else if (slots[SLOT_ATTN].color != 0) drive_leds(slots[SLOT_ATTN]);
    else if (slots[SLOT_BATT].color != 0) drive_leds(slots[SLOT_BATT]);
    else begin
      red_q = '0;
      green_q = '0;
      red_flash_q = '0;
      green_flash_q = '0;
    end
  endfunction

  // update the register copies for one request and report them
  function automatic light_outputs_t apply_light_request(input light_request_t it);
    light_outputs_t o;
    light_req_t r;
    int unsigned level;
    o.status = STATUS_OK;
    r = '{it.color, it.timed, it.on_ms, it.off_ms};
    case (it.light_id)
      LIGHT_BACKLIGHT: begin
        level = (77 * it.color[23:16] + 150 * it.color[15:8] + 29 * it.color[7:0]) >> 8;
        if (panel_max_q != PANEL_UNSCALED) level = (level * panel_max_q) / 255;
        backlight_q = level[15:0];
      end
      LIGHT_BATTERY: begin
        slots[SLOT_BATT] = r;
        refresh_indicators();
      end
      LIGHT_NOTIF: begin
        slots[SLOT_NOTIF] = r;
        refresh_indicators();
      end
      LIGHT_ATTN: begin
        slots[SLOT_ATTN] = r;
        refresh_indicators();
      end
      default: o.status = STATUS_UNSUPPORTED;
    endcase
    o.backlight = backlight_q;
    o.red = red_q;
    o.green = green_q;
    o.red_flash = red_flash_q;
    o.green_flash = green_flash_q;
    return o;
  endfunction

  // on and off times: zero, full scale, tiny and random
  function automatic logic [MS_W-1:0] random_ms();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return MS_W'($urandom_range(1, 20));
      3: return MS_W'($urandom_range(1, 255));
      default: return MS_W'($urandom());
    endcase
  endfunction

  // mostly supported ids, colors biased toward single channels and dark
  function automatic light_request_t random_request();
    light_request_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) it.light_id = LIGHT_BACKLIGHT;
    else if (pick < 45) it.light_id = LIGHT_BATTERY;
    else if (pick < 70) it.light_id = LIGHT_NOTIF;
    else if (pick < 90) it.light_id = LIGHT_ATTN;
    else begin
      case ($urandom_range(3))
        0: it.light_id = LIGHT_SPARE_1;
        1: it.light_id = LIGHT_SPARE_2;
        2: it.light_id = LIGHT_SPARE_6;
        default: it.light_id = LIGHT_SPARE_7;
      endcase
    end
    case ($urandom_range(9))
      0: it.color = '0;
      1: it.color = {8'($urandom_range(1, 255)), 16'h0000};
      2: it.color = {8'h00, 8'($urandom_range(1, 255)), 8'h00};
      3: it.color = {16'h0000, 8'($urandom_range(1, 255))};
      4: it.color = '1;
      default: it.color = COLOR_W'($urandom());
    endcase
    it.timed = ($urandom_range(9) < 6);
    it.on_ms = random_ms();
    it.off_ms = random_ms();
    return it;
  endfunction

  // offer one request, note its outputs when it is taken
  task automatic send_request(input light_request_t it, input logic typed_in,
                              input light_outputs_t want);
    light_outputs_t predicted;
    @(negedge clk);
    while (take_a_gap()) begin
      req_ch.valid = 1'b0;
      {req_ch.light_id, req_ch.color, req_ch.flash_timed, req_ch.on_ms, req_ch.off_ms} =
        REQ_BITS'({$urandom(), $urandom()});
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.light_id = it.light_id;
    req_ch.color = it.color;
    req_ch.flash_timed = it.timed;
    req_ch.on_ms = it.on_ms;
    req_ch.off_ms = it.off_ms;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_light_request(it);
    pending_outputs = {pending_outputs, (typed_in ? want : predicted)};
  endtask

  // drop valid and let every owed result come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write the panel maximum, then read it back
  task automatic set_panel_max(input logic [PANEL_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PANEL_MAX_ADDR;
    pwdata = {16'h0000, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    panel_max_q = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[PANEL_W-1:0] !== value) begin
      $error("panel_max_brightness: expected %0d, got %0d", value, prdata[PANEL_W-1:0]);
      mismatch_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result side: random stalls
  always @(negedge clk) begin
    rsp_ch.ready = !take_a_gap();
  end

  // result side: compare against the oldest owed outputs
  always @(posedge clk) begin
    light_outputs_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_outputs.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_ch.status));
        check_field("backlight_level", 32'(want.backlight), 32'(rsp_ch.backlight_level));
        check_field("red_level", 32'(want.red), 32'(rsp_ch.red_level));
        check_field("green_level", 32'(want.green), 32'(rsp_ch.green_level));
        check_field("red_flash", 32'(want.red_flash), 32'(rsp_ch.red_flash));
        check_field("green_flash", 32'(want.green_flash), 32'(rsp_ch.green_flash));
      end
    end
  end

  // main sequence
  initial begin
    logic [PANEL_W-1:0] setting;
    req_ch.valid = 1'b0;
    req_ch.light_id = '0;
    req_ch.color = '0;
    req_ch.flash_timed = 1'b0;
    req_ch.on_ms = '0;
    req_ch.off_ms = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table, panel at its reset value
    foreach (directed_rows[i])
      send_request(directed_rows[i].item, directed_rows[i].typed_in, directed_rows[i].want);
    drain();

    // random phases, one panel setting each
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: setting = 16'd0;
        1: setting = 16'hffff;
        2: setting = 16'd1;
        3: setting = PANEL_UNSCALED;
        4: setting = 16'd254;
        5: setting = 16'd256;
        6: setting = PANEL_W'($urandom());
        default: setting = PANEL_RESET;
      endcase
      set_panel_max(setting);
      calm = (p == CALM_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(random_request(), 1'b0, NO_CHECK);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/lpbc_pkg.sv
src/lpbc_if.sv
src/lpbc_div.sv
src/led_priority_blink_controller.sv
src/lpbc_checker.sv
sim/tb.sv
